### rtl/msq_pkg.sv
// Package for the marching squares cell unit: field widths, edge codes,
// case table and shared structs. No dependencies.
`default_nettype none
package msq_pkg;
    localparam int W = 16;
    localparam logic signed [W-1:0] ISO_RESET = 16'sd819;

    typedef enum logic [1:0] {
        EDGE_BOTTOM = 2'd0,
        EDGE_RIGHT  = 2'd1,
        EDGE_TOP    = 2'd2,
        EDGE_LEFT   = 2'd3
    } t_edge;

    // One interpolation job: one endpoint on one edge
    typedef struct packed {
        logic signed [W-1:0] fa;
        logic signed [W-1:0] fb;
        logic signed [W-1:0] pa;
        logic signed [W-1:0] pb;
        logic signed [W-1:0] fixed_coord;
        logic                coord_is_x;
    } t_point_job;

    // One segment job queued between classifier and interpolator
    typedef struct packed {
        t_point_job p0;
        t_point_job p1;
        logic       last;
    } t_seg_job;

    // Edge pair of segment k for a case
    function automatic logic [3:0] seg_edges(input logic [3:0] cs, input logic k);
        logic [7:0] row;
        unique case (cs)
            4'd1:    row = {2'd0, 2'd0, 2'd3, 2'd0};
            4'd2:    row = {2'd0, 2'd0, 2'd1, 2'd0};
            4'd3:    row = {2'd0, 2'd0, 2'd3, 2'd1};
            4'd4:    row = {2'd0, 2'd0, 2'd3, 2'd2};
            4'd5:    row = {2'd0, 2'd0, 2'd2, 2'd0};
            4'd6:    row = {2'd3, 2'd2, 2'd1, 2'd0};
            4'd7:    row = {2'd0, 2'd0, 2'd2, 2'd1};
            4'd8:    row = {2'd0, 2'd0, 2'd2, 2'd1};
            4'd9:    row = {2'd2, 2'd1, 2'd3, 2'd0};
            4'd10:   row = {2'd0, 2'd0, 2'd2, 2'd0};
            4'd11:   row = {2'd0, 2'd0, 2'd3, 2'd2};
            4'd12:   row = {2'd0, 2'd0, 2'd3, 2'd1};
            4'd13:   row = {2'd0, 2'd0, 2'd1, 2'd0};
            4'd14:   row = {2'd0, 2'd0, 2'd3, 2'd0};
            default: row = 8'd0;
        endcase
        return k ? row[7:4] : row[3:0];
    endfunction

    function automatic logic [1:0] seg_count(input logic [3:0] cs);
        if (cs == 4'd0 || cs == 4'd15) return 2'd0;
        if (cs == 4'd6 || cs == 4'd9) return 2'd2;
        return 2'd1;
    endfunction
endpackage
`default_nettype wire

### rtl/msq_front.sv
// Front end: takes cells, classifies corners against the isovalue and
// queues one job per segment. Depends on msq_pkg.
`default_nettype none
module msq_front (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire signed [15:0]        i_iso,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire [127:0]              i_data,
    output msq_pkg::t_seg_job        o_job,
    output logic                     o_job_valid,
    input  wire                      i_job_ready
);
    logic signed [15:0] f [4];
    logic [3:0]  cs;
    logic [1:0]  n_segs;
    // held cell with pending second segment
    logic        r_pend;
    logic [127:0] r_data;
    logic [3:0]  r_cs;

    // Build a point job for an edge of a cell
    function automatic msq_pkg::t_point_job mk(input logic [1:0] e,
            input logic [127:0] d);
        msq_pkg::t_point_job j;
        logic signed [15:0] a, b, c, dd, l, r, bt, tp;
        a = d[15:0]; b = d[31:16]; c = d[47:32]; dd = d[63:48];
        l = d[79:64]; r = d[95:80]; bt = d[111:96]; tp = d[127:112];
        unique case (msq_pkg::t_edge'(e))
            msq_pkg::EDGE_BOTTOM: j = '{a, b, l, r, bt, 1'b1};
            msq_pkg::EDGE_RIGHT:  j = '{b, dd, bt, tp, r, 1'b0};
            msq_pkg::EDGE_TOP:    j = '{c, dd, l, r, tp, 1'b1};
            default:              j = '{a, c, bt, tp, l, 1'b0};
        endcase
        return j;
    endfunction

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            f[i]  = i_data[16*i +: 16];
            cs[i] = f[i] > i_iso;
        end
        n_segs = msq_pkg::seg_count(cs);
    end

    // Accept a new cell unless a second segment is still pending or a crossed cell finds the queue full
    assign o_ready = !r_pend && (i_job_ready || !i_valid || n_segs == 2'd0);

    always_comb begin
        logic [3:0] ee;
        if (r_pend) begin
            ee = msq_pkg::seg_edges(r_cs, 1'b1);
            o_job = '{mk(ee[1:0], r_data), mk(ee[3:2], r_data), 1'b1};
            o_job_valid = 1'b1;
        end else begin
            ee = msq_pkg::seg_edges(cs, 1'b0);
            o_job = '{mk(ee[1:0], i_data), mk(ee[3:2], i_data), n_segs == 2'd1};
            o_job_valid = i_valid && n_segs != 2'd0;
        end
    end

    // Hold ambiguous cells for their second segment
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (r_pend) begin
            if (i_job_ready) r_pend <= 1'b0;
        end else if (i_valid && o_ready && n_segs == 2'd2) begin
            r_pend <= 1'b1;
        end
        if (!r_pend) begin
            r_data <= i_data;
            r_cs   <= cs;
        end
    end
endmodule
`default_nettype wire

### rtl/msq_fifo.sv
// Two-entry queue of segment jobs between front and back end.
// Depends on msq_pkg.
`default_nettype none
module msq_fifo (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  msq_pkg::t_seg_job  i_job,
    input  wire                i_valid,
    output logic               o_ready,
    output msq_pkg::t_seg_job  o_job,
    output logic               o_valid,
    input  wire                i_ready
);
    msq_pkg::t_seg_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic wr, rd;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
        if (wr) r_mem[r_wp] <= i_job;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !rd) |=> r_cnt == 2'd2)
        else $error("queue lost an entry");
endmodule
`default_nettype wire

### rtl/msq_back.sv
// Back end: interpolates both endpoints of a segment with a shared
// radix-2 divider (one quotient bit per cycle). Depends on msq_pkg.
`default_nettype none
module msq_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire signed [15:0]  i_iso,
    input  msq_pkg::t_seg_job  i_job,
    input  wire                i_valid,
    output logic               o_ready,
    output logic [63:0]        o_data,
    output logic               o_last,
    output logic               o_valid,
    input  wire                i_ready
);
    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} t_state;
    t_state r_state;
    msq_pkg::t_seg_job r_job;
    logic        r_pt;
    logic [34:0] r_num, r_rem;
    logic [17:0] r_den;
    logic [35:0] r_quo;
    logic [5:0]  r_cnt;
    logic        r_neg;
    logic signed [15:0] r_res0x, r_res0y;
    msq_pkg::t_point_job pj;
    logic signed [16:0] num, den, dl;
    logic signed [33:0] prod;
    logic [35:0] rem_sh;
    logic signed [37:0] sum;
    logic signed [15:0] sat, px, py;
    logic        emit;

    assign pj   = r_pt ? r_job.p1 : r_job.p0;
    assign num  = 17'(i_iso) - 17'(pj.fa);
    assign den  = 17'(pj.fb) - 17'(pj.fa);
    assign dl   = 17'(pj.pb) - 17'(pj.pa);
    assign prod = num * dl;
    assign rem_sh = {r_rem, r_num[34]};
    // q = (2|p| + |den|) / (2|den|)
    always_comb begin
        logic signed [37:0] q;
        q   = r_neg ? -$signed({2'b0, r_quo}) : $signed({2'b0, r_quo});
        sum = 38'(pj.pa) + q;
        if (sum > 38'sd32767) sat = 16'sh7fff;
        else if (sum < -38'sd32768) sat = 16'sh8000;
        else sat = sum[15:0];
        px = pj.coord_is_x ? sat : pj.fixed_coord;
        py = pj.coord_is_x ? pj.fixed_coord : sat;
    end

    // Finish a segment once the output register is free
    assign emit    = r_state == S_DONE && r_pt && (!o_valid || i_ready);
    assign o_ready = r_state == S_IDLE;

    // Sequence: multiply, divide bit by bit, store point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (emit) o_valid <= 1'b1;
            else if (o_valid && i_ready) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid && o_ready) begin
                    r_job <= i_job; r_pt <= 1'b0; r_state <= S_MUL;
                end
                S_MUL: begin
                    logic [33:0] mp;
                    logic [16:0] md;
                    mp = prod[33] ? 34'(-prod) : 34'(prod);
                    md = den[16] ? 17'(-den) : 17'(den);
                    r_neg <= prod[33] ^ den[16] && prod != 0;
                    r_num <= {mp, 1'b0} + 35'(md);
                    r_den <= {md, 1'b0};
                    r_rem <= '0; r_quo <= '0;
                    r_cnt <= 6'd34;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (rem_sh >= 36'(r_den)) begin
                        r_rem <= 35'(rem_sh - 36'(r_den));
                        r_quo <= {r_quo[34:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh[34:0];
                        r_quo <= {r_quo[34:0], 1'b0};
                    end
                    r_num <= {r_num[33:0], 1'b0};
                    if (r_cnt == 6'd0) r_state <= S_DONE;
                    else r_cnt <= r_cnt - 6'd1;
                end
                default: begin
                    if (!r_pt) begin
                        r_res0x <= den == 0 ? (pj.coord_is_x ? pj.pa : px) : px;
                        r_res0y <= den == 0 ? (pj.coord_is_x ? py : pj.pa) : py;
                        r_pt <= 1'b1; r_state <= S_MUL;
                    end else if (emit) begin
                        o_data  <= {den == 0 ? (pj.coord_is_x ? py : pj.pa) : py,
                                    den == 0 ? (pj.coord_is_x ? pj.pa : px) : px,
                                    r_res0y, r_res0x};
                        o_last  <= r_job.last;
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("result dropped while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> r_den != '0)
        else $error("zero divisor on a crossed edge");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid && o_ready) |=> r_state == S_MUL)
        else $error("job not started");
endmodule
`default_nettype wire

### rtl/marching_squares_cell_top.sv
// Marching squares cell unit, top level. Instantiates msq_front,
// msq_fifo and msq_back; depends on msq_pkg.
// Each cell yields zero, one or two segments. Endpoints are interpolated by
// one shared bit-serial divider: a segment is taken as a job, then its two
// points each go through one multiply step, 35 divide steps and one store
// step, and the divider takes no new segment before the last one is emitted.
// Cells with no crossing queue no job and are taken even when the queue is
// full, unless a second segment is pending. A two-entry queue lets the
// classifier take cells while the divider works, and the divider can work
// on the next segment while a finished segment waits in the output register.
`default_nettype none
module marching_squares_cell_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [15:0]  i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // value_low_left, value_low_right, value_high_left, value_high_right,
    // left_x, right_x, bottom_y, top_y
    input  wire [127:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // start_x, start_y, end_x, end_y
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    logic signed [15:0] r_iso;
    msq_pkg::t_seg_job  fj, qj;
    logic fv, fr, qv, qr;

    assign o_cfg_ready = 1'b1;
    // Hold the isovalue register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_iso <= msq_pkg::ISO_RESET;
        else if (i_cfg_valid) r_iso <= i_cfg_data;
    end

    msq_front u_front (.i_clk, .i_rst_n, .i_iso(r_iso), .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready), .i_data(s_axis_tdata), .o_job(fj),
        .o_job_valid(fv), .i_job_ready(fr));
    msq_fifo u_fifo (.i_clk, .i_rst_n, .i_job(fj), .i_valid(fv), .o_ready(fr),
        .o_job(qj), .o_valid(qv), .i_ready(qr));
    msq_back u_back (.i_clk, .i_rst_n, .i_iso(r_iso), .i_job(qj), .i_valid(qv),
        .o_ready(qr), .o_data(m_axis_tdata), .o_last(m_axis_tlast),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready));
endmodule
`default_nettype wire
